@@ src/cpd_pkg.sv @@
// Shared types and constants of the channel phantom packet detector.
package cpd_pkg;

  // Field widths
  localparam int PCT_W  = 7;
  localparam int TIME_W = 64;
  localparam int CNT_W  = 16;
  localparam int ST_W   = 2;
  localparam int CLS_W  = 2;
  localparam int SLOT_W = 4;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Stream payload widths (packed, padded to bytes)
  localparam int IN_BITS  = 2 * PCT_W + TIME_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = CLS_W + 2 * ST_W + 1 + SLOT_W + 1 + 3 * TIME_W + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Tracker states
  localparam logic [ST_W-1:0] ST_SILENCE = 2'd0;
  localparam logic [ST_W-1:0] ST_STRANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_RX      = 2'd2;

  // Sample classes
  localparam logic [CLS_W-1:0] CLS_NONE    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SILENCE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_STRANGE = 2'd2;
  localparam logic [CLS_W-1:0] CLS_RX      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN = 2'd2;

  // Configuration reset values
  localparam logic [PCT_W-1:0] UPPER_RST   = 7'd70;
  localparam logic [PCT_W-1:0] LOWER_RST   = 7'd30;
  localparam logic [CNT_W-1:0] MIN_RUN_RST = 16'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Per-sample class test results
  typedef struct packed {
    logic is_rx;
    logic is_sil;
    logic is_str;
  } class_flags_t;

  // One result item
  typedef struct packed {
    logic [CLS_W-1:0]  sample_class;
    logic [ST_W-1:0]   state_now;
    logic              changed;
    logic [ST_W-1:0]   old_state;
    logic [SLOT_W-1:0] log_slot;
    logic              phantom_valid;
    logic [TIME_W-1:0] phantom_start_time;
    logic [TIME_W-1:0] phantom_stop_time;
    logic [TIME_W-1:0] phantom_len;
    logic [CNT_W-1:0]  run_count;
  } result_t;

  // Saturating increment
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    bump = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

endpackage

@@ src/channel_phantom_packet_detector_top.sv @@
// Top level: stream ports, configuration registers, input and result registers.
// An accepted input transaction is held in the input register, and its result is
// then held in the result register. Throughput: one sample per cycle while m_tready
// does not stall the output; the state update runs between the input and result registers.
// Reset (rst, synchronous): thresholds 70/30, minimum run 4, tracker in silence
// with all counters, log index and run start time cleared, both stages empty.
module channel_phantom_packet_detector_top #(
  parameter int LOG_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // busy_pct, recv_pct, sample_time, zero pad
  input  logic [cpd_pkg::IN_W-1:0]         s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // sample_class, state_now, changed, old_state, log_slot, phantom_valid,
  // phantom_start_time, phantom_stop_time, phantom_len, run_count, zero pad
  output logic [cpd_pkg::OUT_W-1:0]        m_tdata,
  input  logic                             cfg_write,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpd_pkg::CFG_W-1:0]        cfg_data
);

  logic [cpd_pkg::PCT_W-1:0]  upper_threshold;
  logic [cpd_pkg::PCT_W-1:0]  lower_threshold;
  logic [cpd_pkg::CNT_W-1:0]  min_strange_run;

  logic                       in_valid;
  logic [cpd_pkg::PCT_W-1:0]  in_busy;
  logic [cpd_pkg::PCT_W-1:0]  in_recv;
  logic [cpd_pkg::TIME_W-1:0] in_time;

  logic                       out_valid;
  cpd_pkg::result_t           out_res;

  logic                       step;
  cpd_pkg::class_flags_t      flags;
  logic [cpd_pkg::CLS_W-1:0]  sample_class;
  cpd_pkg::result_t           result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_threshold <= cpd_pkg::UPPER_RST;
      lower_threshold <= cpd_pkg::LOWER_RST;
      min_strange_run <= cpd_pkg::MIN_RUN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        cpd_pkg::CFG_UPPER:   upper_threshold <= cfg_data[cpd_pkg::PCT_W-1:0];
        cpd_pkg::CFG_LOWER:   lower_threshold <= cfg_data[cpd_pkg::PCT_W-1:0];
        cpd_pkg::CFG_MIN_RUN: min_strange_run <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_busy <= s_tdata[cpd_pkg::PCT_W-1:0];
      in_recv <= s_tdata[2*cpd_pkg::PCT_W-1:cpd_pkg::PCT_W];
      in_time <= s_tdata[2*cpd_pkg::PCT_W+cpd_pkg::TIME_W-1:2*cpd_pkg::PCT_W];
    end
  end

  cpd_classify u_classify (
    .busy_pct        (in_busy),
    .recv_pct        (in_recv),
    .upper_threshold (upper_threshold),
    .lower_threshold (lower_threshold),
    .flags           (flags),
    .sample_class    (sample_class)
  );

  cpd_tracker #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_tracker (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .flags           (flags),
    .sample_class    (sample_class),
    .sample_time     (in_time),
    .min_strange_run (min_strange_run),
    .result          (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(cpd_pkg::OUT_W - cpd_pkg::OUT_BITS){1'b0}},
                     out_res.run_count,
                     out_res.phantom_len,
                     out_res.phantom_stop_time,
                     out_res.phantom_start_time,
                     out_res.phantom_valid,
                     out_res.log_slot,
                     out_res.old_state,
                     out_res.changed,
                     out_res.state_now,
                     out_res.sample_class};

  // A phantom report only comes with a transition out of strange
  a_phantom_exit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.phantom_valid |->
      out_res.changed && out_res.old_state == cpd_pkg::ST_STRANGE &&
      out_res.state_now != cpd_pkg::ST_STRANGE)
    else $error("phantom report without a strange exit");

  // Without a transition the state stays and no slot is shown
  a_no_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.changed |->
      out_res.log_slot == '0 && out_res.state_now == out_res.old_state)
    else $error("state moved or slot shown without a transition");

  // A held sample moves into an empty result register in the next cycle
  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("sample stuck in input register");

  // Consecutive results chain: each old_state is the last state_now
  a_chain: assert property (@(posedge clk) disable iff (rst)
    step && out_valid |=> out_res.old_state == $past(out_res.state_now))
    else $error("state chain broken between results");

endmodule

@@ src/cpd_classify.sv @@
// Threshold classification of one channel-utility sample.
module cpd_classify (
  input  logic [cpd_pkg::PCT_W-1:0] busy_pct,
  input  logic [cpd_pkg::PCT_W-1:0] recv_pct,
  input  logic [cpd_pkg::PCT_W-1:0] upper_threshold,
  input  logic [cpd_pkg::PCT_W-1:0] lower_threshold,
  output cpd_pkg::class_flags_t     flags,
  output logic [cpd_pkg::CLS_W-1:0] sample_class
);

  logic b_mid;

  // Each test stands on its own; crossed thresholds may hit several
  assign b_mid = (busy_pct > lower_threshold) && (busy_pct < upper_threshold);

  always_comb begin
    flags.is_rx  = (busy_pct >= upper_threshold) && (recv_pct >= upper_threshold);
    flags.is_sil = (busy_pct <= lower_threshold) && (recv_pct <= lower_threshold);
    flags.is_str = (b_mid && (recv_pct < lower_threshold)) ||
                   (b_mid && (recv_pct > lower_threshold) && (recv_pct < upper_threshold)) ||
                   ((busy_pct > upper_threshold) && (recv_pct < lower_threshold));
  end

  // Reported class: rx before silence before strange
  always_comb begin
    if (flags.is_rx) begin
      sample_class = cpd_pkg::CLS_RX;
    end else if (flags.is_sil) begin
      sample_class = cpd_pkg::CLS_SILENCE;
    end else if (flags.is_str) begin
      sample_class = cpd_pkg::CLS_STRANGE;
    end else begin
      sample_class = cpd_pkg::CLS_NONE;
    end
  end

endmodule

@@ src/cpd_tracker.sv @@
// State machine, run counters, transition log index and phantom report.
module cpd_tracker #(
  parameter int LOG_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  cpd_pkg::class_flags_t      flags,
  input  logic [cpd_pkg::CLS_W-1:0]  sample_class,
  input  logic [cpd_pkg::TIME_W-1:0] sample_time,
  input  logic [cpd_pkg::CNT_W-1:0]  min_strange_run,
  output cpd_pkg::result_t           result
);

  localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam logic [LW-1:0] LOG_LAST = LW'(LOG_DEPTH - 1);

  logic [cpd_pkg::ST_W-1:0]   cur_state, cur_state_next;
  logic                       strange_mode, strange_mode_next;
  logic [cpd_pkg::CNT_W-1:0]  strange_count, strange_count_next;
  logic [cpd_pkg::CNT_W-1:0]  silence_count, silence_count_next;
  logic [cpd_pkg::CNT_W-1:0]  receive_count, receive_count_next;
  logic [cpd_pkg::CNT_W-1:0]  mode_entry_count, mode_entry_count_next;
  logic [LW-1:0]              log_index, log_index_next;
  logic [cpd_pkg::TIME_W-1:0] run_start_time, run_start_time_next;

  logic                       changed, phantom;
  logic [cpd_pkg::CNT_W-1:0]  run;
  logic [LW+3:0]              slot_ext;

  // Transition rules, first match wins
  always_comb begin
    cur_state_next        = cur_state;
    strange_mode_next     = strange_mode;
    strange_count_next    = strange_count;
    silence_count_next    = silence_count;
    receive_count_next    = receive_count;
    mode_entry_count_next = mode_entry_count;
    run_start_time_next   = run_start_time;
    changed               = 1'b0;
    phantom               = 1'b0;
    if (!strange_mode && cur_state == cpd_pkg::ST_RX && flags.is_sil) begin
      // rx to silence wins over a strange entry from rx
      receive_count_next = '0;
      cur_state_next     = cpd_pkg::ST_SILENCE;
      silence_count_next = cpd_pkg::bump(silence_count);
      changed            = 1'b1;
    end else if (!strange_mode && flags.is_str &&
        (cur_state == cpd_pkg::ST_SILENCE || cur_state == cpd_pkg::ST_RX)) begin
      // enter strange from silence or rx
      run_start_time_next   = sample_time;
      strange_mode_next     = 1'b1;
      mode_entry_count_next = cpd_pkg::bump(mode_entry_count);
      cur_state_next        = cpd_pkg::ST_STRANGE;
      strange_count_next    = cpd_pkg::bump(strange_count);
      changed               = 1'b1;
    end else if (strange_mode && cur_state == cpd_pkg::ST_STRANGE &&
                 (flags.is_rx || flags.is_sil)) begin
      // leave strange; a long enough run is a phantom packet
      if (strange_count >= min_strange_run) begin
        phantom             = 1'b1;
        receive_count_next  = '0;
        silence_count_next  = '0;
        run_start_time_next = '0;
      end
      strange_mode_next     = 1'b0;
      mode_entry_count_next = '0;
      strange_count_next    = '0;
      changed               = 1'b1;
      if (flags.is_rx) begin
        cur_state_next     = cpd_pkg::ST_RX;
        receive_count_next = cpd_pkg::bump(phantom ? '0 : receive_count);
      end else begin
        cur_state_next     = cpd_pkg::ST_SILENCE;
        silence_count_next = cpd_pkg::bump(phantom ? '0 : silence_count);
      end
    end else if (cur_state == cpd_pkg::ST_STRANGE && flags.is_str) begin
      strange_count_next = cpd_pkg::bump(strange_count);
    end else if (cur_state == cpd_pkg::ST_SILENCE && flags.is_sil) begin
      silence_count_next = cpd_pkg::bump(silence_count);
    end else if (!strange_mode && cur_state == cpd_pkg::ST_RX && flags.is_rx) begin
      receive_count_next = cpd_pkg::bump(receive_count);
    end
  end

  // Log ring index
  assign log_index_next = !changed ? log_index :
                          (log_index == LOG_LAST) ? '0 : log_index + 1'b1;
  assign slot_ext = {4'b0, log_index};

  // Counter of the state after the sample
  always_comb begin
    case (cur_state_next)
      cpd_pkg::ST_SILENCE: run = silence_count_next;
      cpd_pkg::ST_STRANGE: run = strange_count_next;
      default:             run = receive_count_next;
    endcase
  end

  // Result item
  always_comb begin
    result.sample_class       = sample_class;
    result.state_now          = cur_state_next;
    result.changed            = changed;
    result.old_state          = cur_state;
    result.log_slot           = changed ? slot_ext[3:0] : '0;
    result.phantom_valid      = phantom;
    result.phantom_start_time = phantom ? run_start_time : '0;
    result.phantom_stop_time  = phantom ? sample_time : '0;
    result.phantom_len        = phantom ? sample_time - run_start_time : '0;
    result.run_count          = run;
  end

  // State update, once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state        <= cpd_pkg::ST_SILENCE;
      strange_mode     <= 1'b0;
      strange_count    <= '0;
      silence_count    <= '0;
      receive_count    <= '0;
      mode_entry_count <= '0;
      log_index        <= '0;
      run_start_time   <= '0;
    end else if (step) begin
      cur_state        <= cur_state_next;
      strange_mode     <= strange_mode_next;
      strange_count    <= strange_count_next;
      silence_count    <= silence_count_next;
      receive_count    <= receive_count_next;
      mode_entry_count <= mode_entry_count_next;
      log_index        <= log_index_next;
      run_start_time   <= run_start_time_next;
    end
  end

endmodule
